[rtl/core/jdzpwm_pkg.sv]
// ----------------------------------------------------------------------------
// jdzpwm_pkg
// Shared constants, widths and link types for the joystick dead-zone PWM block.
// ----------------------------------------------------------------------------
package jdzpwm_pkg;

  localparam int PERIOD_TICKS = 20;   // 2..32
  localparam int CAL_SAMPLES  = 10;   // 1..15

  localparam int ADC_W    = 12;
  localparam int ADC_FULL = 4095;
  localparam int REVM_W   = 5;
  localparam int SUM_W    = 16;
  localparam int CNT_W    = 4;
  localparam int DUTY_OUT_W = 5;

  // multiplier operand wide enough for PERIOD_TICKS and reverse_multiplier
  localparam int PER_W  = $clog2(PERIOD_TICKS + 1);
  localparam int MULT_W = (PER_W > REVM_W) ? PER_W : REVM_W;
  localparam int PROD_W = ADC_W + MULT_W;
  localparam int DIV_NW = (PROD_W > SUM_W) ? PROD_W : SUM_W;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam int TICK_W = $clog2(PERIOD_TICKS);

  // register map, word index = paddr[2]
  localparam int  PADDR_W       = 3;
  localparam logic CFG_DEAD_ZONE = 1'b0;
  localparam logic CFG_REV_MULT  = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [ADC_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic              load;
    logic              fwd;
    logic              rev;
    logic [TICK_W-1:0] duty;
  } pwm_cmd_t;

endpackage

[rtl/core/jdzpwm_div.sv]
// ----------------------------------------------------------------------------
// jdzpwm_div
// Restoring radix-2 divider, one quotient bit per cycle. Shared by the
// calibration average and the duty scaling.
// ----------------------------------------------------------------------------
module jdzpwm_div
  import jdzpwm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [ADC_W-1:0]  rem;
  logic [DIV_NW-1:0] quo;
  logic [ADC_W-1:0]  den;
  logic              done;

  logic [ADC_W:0]    shifted;
  logic              fits;

  always_comb begin
    shifted = {rem, quo[DIV_NW-1]};
    fits    = (shifted >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_NW);
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        rem <= fits ? ADC_W'(shifted - {1'b0, den}) : shifted[ADC_W-1:0];
        quo <= {quo[DIV_NW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

[rtl/core/jdzpwm_tick.sv]
// ----------------------------------------------------------------------------
// jdzpwm_tick
// PWM period emitter: one output word per tick, PERIOD_TICKS words per load.
// ----------------------------------------------------------------------------
module jdzpwm_tick
  import jdzpwm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  pwm_cmd_t              cmd,
  output logic                  finished,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  forward_pin,
  output logic                  reverse_pin,
  output logic [DUTY_OUT_W-1:0] duty_ticks,
  output logic                  last_tick
);

  logic [TICK_W-1:0] cnt;
  logic [TICK_W-1:0] duty;
  logic              fwd;
  logic              rev;
  logic              on;

  always_comb begin
    on          = (cnt < duty);
    forward_pin = fwd & on;
    reverse_pin = rev & on;
    duty_ticks  = DUTY_OUT_W'(duty);
    last_tick   = (cnt == TICK_W'(PERIOD_TICKS - 1));
    finished    = out_valid & ~out_stall & last_tick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cmd.load) begin
        out_valid <= 1'b1;
        cnt       <= '0;
        duty      <= cmd.duty;
        fwd       <= cmd.fwd;
        rev       <= cmd.rev;
      end else if (out_valid && !out_stall) begin
        if (last_tick) begin
          out_valid <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/joystick_deadzone_motor_pwm.sv]
// ----------------------------------------------------------------------------
// joystick_deadzone_motor_pwm
// Joystick dead-zone H-bridge PWM: calibrates a mid point, then turns each
// sample into one PWM period of pin levels, scaling duty outside the dead zone through a shared serial divider.
// ----------------------------------------------------------------------------
// Calibration samples: one per cycle, no words out; the last one stalls the
//   input for the average (ST_CAL_DIV) and the span setup (ST_SPAN).
// Drive samples: ST_OFFSET, ST_MUL and the divider (ST_DIV) lie before the
//   first tick word, ST_OFFSET alone in the dead zone, then PERIOD_TICKS words;
//   the next sample is taken the cycle after the last tick word.
// Reset (rst, synchronous): calibration restarts, deadband=20, reverse_multiplier=10.
module joystick_deadzone_motor_pwm
  import jdzpwm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADC_W-1:0]      sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  forward_pin,
  output logic                  reverse_pin,
  output logic [DUTY_OUT_W-1:0] duty_ticks,
  output logic                  last_tick
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CAL_DIV, ST_SPAN, ST_OFFSET, ST_MUL, ST_DIV, ST_EMIT
  } state_t;

  state_t state;

  logic [ADC_W-1:0]  deadband;
  logic [REVM_W-1:0] reverse_multiplier;

  logic [CNT_W-1:0]  calibration_count;
  logic [SUM_W-1:0]  calibration_sum;
  logic [ADC_W-1:0]  center_value;
  logic [ADC_W-1:0]  span_positive;
  logic [ADC_W-1:0]  span_negative;

  logic [ADC_W-1:0]  smp;
  logic              fwd;
  logic              rev;
  logic [ADC_W-1:0]  excess;
  logic [MULT_W-1:0] mult;

  div_req_t div_req;
  div_rsp_t div_rsp;
  pwm_cmd_t pwm_cmd;
  logic     finished;

  // config port
  logic wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      CFG_DEAD_ZONE: prdata = 32'(deadband);
      CFG_REV_MULT:  prdata = 32'(reverse_multiplier);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband           <= ADC_W'(20);
      reverse_multiplier <= REVM_W'(10);
    end else if (wr_en) begin
      case (paddr[2])
        CFG_DEAD_ZONE: deadband           <= pwdata[ADC_W-1:0];
        CFG_REV_MULT:  reverse_multiplier <= pwdata[REVM_W-1:0];
        default:       ;
      endcase
    end
  end

  // combinational helpers
  logic [ADC_W:0]    cz_sum;
  logic [ADC_W-1:0]  d_pos;
  logic [ADC_W-1:0]  d_neg;
  logic              hit_fwd;
  logic              hit_rev;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  count_next;
  logic [TICK_W-1:0] duty_clamped;
  logic [ADC_W-1:0]  span_sel;

  always_comb begin
    cz_sum     = {1'b0, center_value} + {1'b0, deadband};
    d_pos      = smp - center_value;
    d_neg      = center_value - smp;
    hit_fwd    = (smp > center_value) && (d_pos > deadband);
    hit_rev    = (center_value > smp) && (d_neg > deadband);
    sum_next   = calibration_sum + SUM_W'(sample);
    count_next = calibration_count + 1'b1;
    if (div_rsp.quot > DIV_NW'(PERIOD_TICKS - 1)) begin
      duty_clamped = TICK_W'(PERIOD_TICKS - 1);
    end else begin
      duty_clamped = div_rsp.quot[TICK_W-1:0];
    end
    span_sel = fwd ? span_positive : span_negative;
    if (span_sel == '0) begin
      span_sel = ADC_W'(1);
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      calibration_count <= '0;
      calibration_sum   <= '0;
      center_value      <= '0;
      span_positive     <= '0;
      span_negative     <= '0;
      div_req.start     <= 1'b0;
      pwm_cmd.load      <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      pwm_cmd.load  <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            smp <= sample;
            if (calibration_count < CNT_W'(CAL_SAMPLES)) begin
              calibration_sum   <= sum_next;
              calibration_count <= count_next;
              if (count_next >= CNT_W'(CAL_SAMPLES)) begin
                div_req.start <= 1'b1;
                div_req.num   <= DIV_NW'(sum_next);
                div_req.den   <= ADC_W'(CAL_SAMPLES);
                state         <= ST_CAL_DIV;
              end
            end else begin
              state <= ST_OFFSET;
            end
          end
        end
        ST_CAL_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.quot > DIV_NW'(ADC_FULL)) begin
              center_value <= ADC_W'(ADC_FULL);
            end else begin
              center_value <= div_rsp.quot[ADC_W-1:0];
            end
            state <= ST_SPAN;
          end
        end
        ST_SPAN: begin
          span_positive <= ((ADC_W + 1)'(ADC_FULL) > cz_sum)
                           ? ADC_W'((ADC_W + 1)'(ADC_FULL) - cz_sum) : ADC_W'(1);
          span_negative <= (center_value > deadband)
                           ? (center_value - deadband) : ADC_W'(1);
          state <= ST_IDLE;
        end
        ST_OFFSET: begin
          fwd <= hit_fwd;
          rev <= hit_rev & ~hit_fwd;
          if (hit_fwd) begin
            excess <= d_pos - deadband;
            mult   <= MULT_W'(PERIOD_TICKS);
            state  <= ST_MUL;
          end else if (hit_rev) begin
            excess <= d_neg - deadband;
            mult   <= MULT_W'(reverse_multiplier);
            state  <= ST_MUL;
          end else begin
            pwm_cmd.load <= 1'b1;
            pwm_cmd.fwd  <= 1'b0;
            pwm_cmd.rev  <= 1'b0;
            pwm_cmd.duty <= '0;
            state        <= ST_EMIT;
          end
        end
        ST_MUL: begin
          div_req.start <= 1'b1;
          div_req.num   <= DIV_NW'(PROD_W'(excess) * PROD_W'(mult));
          div_req.den   <= span_sel;
          state         <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            pwm_cmd.load <= 1'b1;
            pwm_cmd.fwd  <= fwd;
            pwm_cmd.rev  <= rev;
            pwm_cmd.duty <= duty_clamped;
            state        <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (finished) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  jdzpwm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  jdzpwm_tick u_tick (
    .clk         (clk),
    .rst         (rst),
    .cmd         (pwm_cmd),
    .finished    (finished),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .forward_pin (forward_pin),
    .reverse_pin (reverse_pin),
    .duty_ticks  (duty_ticks),
    .last_tick   (last_tick)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for joystick_deadzone_motor_pwm: calibrates the mid
// point, then drives directed and random samples through varied dead-zone and
// reverse settings, predicting every PWM tick word and checking it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import jdzpwm_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE_CYCLES = DIV_NW + 8;

  typedef struct packed {
    logic                  fwd;
    logic                  rev;
    logic [DUTY_OUT_W-1:0] duty;
    logic                  last;
  } tick_word_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ADC_W-1:0]      sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  forward_pin;
  logic                  reverse_pin;
  logic [DUTY_OUT_W-1:0] duty_ticks;
  logic                  last_tick;

  // motor model state and register copies
  int cal_cnt = 0;
  int cal_sum = 0;
  int mid = 0;
  int span_pos = 0;
  int span_neg = 0;
  int dz = 20;
  int revm = 10;

  tick_word_t tick_q[$];

  int errors = 0;
  int samples_sent = 0;
  int periods = 0;
  int words_checked = 0;
  int reg_writes = 0;
  int cycles = 0;
  int burst_left = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int stall_left = 0;
  int stall_hold = 0;
  logic stall_level = 1'b0;

  joystick_deadzone_motor_pwm i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .forward_pin(forward_pin),
    .reverse_pin(reverse_pin),
    .duty_ticks (duty_ticks),
    .last_tick  (last_tick)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, tick_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [ADC_W-1:0] clip_adc(input int v);
    if (v < 0) return '0;
    if (v > ADC_FULL) return ADC_FULL[ADC_W-1:0];
    return v[ADC_W-1:0];
  endfunction

  // Calibration words feed the mid point average; drive words queue one full period.
  task automatic predict_period(input logic [ADC_W-1:0] s);
    int sv;
    int span;
    int duty;
    logic fwd;
    logic rev;
    tick_word_t w;
    sv = int'(s);
    if (cal_cnt < CAL_SAMPLES) begin
      cal_sum = (cal_sum + sv) & 16'hFFFF;
      cal_cnt++;
      if (cal_cnt >= CAL_SAMPLES) begin
        mid = cal_sum / CAL_SAMPLES;
        if (mid > ADC_FULL) mid = ADC_FULL;
        // spans freeze the dead zone in force right now
        span_pos = (ADC_FULL > mid + dz) ? ADC_FULL - mid - dz : 1;
        span_neg = (mid > dz) ? mid - dz : 1;
      end
      return;
    end
    fwd = 1'b0;
    rev = 1'b0;
    duty = 0;
    if (sv > mid && sv - mid > dz) begin
      span = (span_pos != 0) ? span_pos : 1;
      fwd = 1'b1;
      duty = ((sv - mid - dz) * PERIOD_TICKS) / span;
    end else if (mid > sv && mid - sv > dz) begin
      span = (span_neg != 0) ? span_neg : 1;
      rev = 1'b1;
      duty = ((mid - sv - dz) * revm) / span;
    end
    if (duty > PERIOD_TICKS - 1) duty = PERIOD_TICKS - 1;
    for (int t = 0; t < PERIOD_TICKS; t++) begin
      w.fwd = fwd && (t < duty);
      w.rev = rev && (t < duty);
      w.duty = duty[DUTY_OUT_W-1:0];
      w.last = (t == PERIOD_TICKS - 1);
      tick_q.push_back(w);
    end
    periods++;
  endtask

  // Entered at a falling edge; valid stays high across bursts.
  task automatic push_sample(input logic [ADC_W-1:0] s);
    int gap;
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (in_stall);
    predict_period(s);
    samples_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Stop sending, let every expected word arrive, then let the block go idle.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (tick_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input logic reg_idx, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {reg_idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_write(input logic reg_idx, input int unsigned value);
    logic [31:0] rd;
    logic [31:0] mask;
    apb_cycle(1'b1, reg_idx, value, rd);
    reg_writes++;
    if (reg_idx == CFG_DEAD_ZONE) begin
      dz = value & 12'hFFF;
      mask = 32'hFFF;
    end else begin
      revm = value & 5'h1F;
      mask = 32'h1F;
    end
    apb_cycle(1'b0, reg_idx, '0, rd);
    if ((rd & mask) != (value & mask))
      begin
        $error("readback reg %0d: expected %0d, actual %0d", reg_idx, value & mask, rd & mask);
        errors++;
      end
  endtask

  always @(posedge clk) begin
    tick_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (tick_q.size() == 0) begin
        $error("unexpected word: forward_pin=%0d reverse_pin=%0d duty_ticks=%0d last_tick=%0d",
               forward_pin, reverse_pin, duty_ticks, last_tick);
        errors++;
      end else begin
        w = tick_q.pop_front();
        words_checked++;
        if (forward_pin !== w.fwd) begin
          $error("forward_pin: expected %0d, actual %0d", w.fwd, forward_pin);
          errors++;
        end
        if (reverse_pin !== w.rev) begin
          $error("reverse_pin: expected %0d, actual %0d", w.rev, reverse_pin);
          errors++;
        end
        if (duty_ticks !== w.duty) begin
          $error("duty_ticks: expected %0d, actual %0d", w.duty, duty_ticks);
          errors++;
        end
        if (last_tick !== w.last) begin
          $error("last_tick: expected %0d, actual %0d", w.last, last_tick);
          errors++;
        end
      end
    end
  end

  // receiver back-pressure: quiet, light, heavy and long on/off stretches
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_hold == 0) begin
          stall_hold = $urandom_range(1, 12);
          stall_level = ~stall_level;
        end
        stall_hold--;
        out_stall <= stall_level;
      end
    endcase
  end

  task automatic test_calibration();
    int c;
    cfg_write(CFG_DEAD_ZONE, ($urandom_range(0, 7) == 0) ? $urandom_range(2000, 4095)
                                                          : $urandom_range(0, 120));
    cfg_write(CFG_REV_MULT, $urandom_range(0, 31));
    case ($urandom_range(0, 7))
      0: c = $urandom_range(0, 100);
      1: c = $urandom_range(3995, 4095);
      default: c = $urandom_range(400, 3700);
    endcase
    for (int i = 0; i < CAL_SAMPLES; i++) begin
      if ($urandom_range(0, 7) == 0) push_sample(clip_adc($urandom_range(0, ADC_FULL)));
      else push_sample(clip_adc(c + int'($urandom_range(0, 80)) - 40));
    end
    // last calibration word yields nothing, so only the settle covers the setup
    drain_and_settle();
  endtask

  task automatic test_drive_edges();
    cfg_write(CFG_DEAD_ZONE, 20);
    cfg_write(CFG_REV_MULT, 10);
    push_sample('0);
    push_sample(ADC_FULL[ADC_W-1:0]);
    push_sample(clip_adc(mid));
    push_sample(clip_adc(mid + dz));
    push_sample(clip_adc(mid - dz));
    // one step past the dead zone: direction set, duty usually zero
    push_sample(clip_adc(mid + dz + 1));
    push_sample(clip_adc(mid - dz - 1));
    push_sample(clip_adc(mid + dz + span_pos / 2));
    push_sample(clip_adc(mid - dz - span_neg / 2));
    push_sample(clip_adc(mid + dz + span_pos));
    push_sample(clip_adc(mid - dz - span_neg));
    push_sample(12'hAAA);
    push_sample(12'h555);
    drain_and_settle();
  endtask

  task automatic test_register_sweep();
    int dz_set[6];
    int revm_set[6];
    dz_set = '{0, 0, 4095, 1, 0, 20};
    revm_set = '{0, 20, 31, 21, 0, 10};
    dz_set[4] = $urandom_range(0, 4095);
    revm_set[4] = $urandom_range(0, 31);
    for (int k = 0; k < 6; k++) begin
      cfg_write(CFG_DEAD_ZONE, dz_set[k]);
      cfg_write(CFG_REV_MULT, revm_set[k]);
      push_sample('0);
      push_sample(ADC_FULL[ADC_W-1:0]);
      push_sample(clip_adc(mid + int'($urandom_range(0, 600)) - 300));
      push_sample(clip_adc(mid - dz - int'($urandom_range(0, span_neg))));
      drain_and_settle();
    end
  endtask

  task automatic test_random_drive(input int count);
    int v;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 39) begin
        drain_and_settle();
        cfg_write(CFG_DEAD_ZONE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                              : $urandom_range(0, 300));
        cfg_write(CFG_REV_MULT, $urandom_range(0, 31));
      end
      if (n == count / 2) drain_and_settle();
      case ($urandom_range(0, 5))
        0: v = $urandom_range(0, ADC_FULL);
        1: v = mid + (($urandom_range(0, 1) != 0) ? dz : -dz) + int'($urandom_range(0, 6)) - 3;
        2, 3: v = mid + dz + int'($urandom_range(0, span_pos + 8));
        4: v = mid - dz - int'($urandom_range(0, span_neg + 8));
        default: v = ($urandom_range(0, 1) != 0) ? ADC_FULL : 0;
      endcase
      push_sample(clip_adc(v));
    end
    drain_and_settle();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_calibration();
    test_drive_edges();
    test_register_sweep();
    test_random_drive(230);
    $display("run: %0d samples (%0d calibration), %0d periods, %0d tick words, %0d reg writes",
             samples_sent, CAL_SAMPLES, periods, words_checked, reg_writes);
    $display("mid point %0d, spans +%0d / -%0d, extremes of dead zone and reverse scale swept",
             mid, span_pos, span_neg);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
